### src/cfd_pkg.sv
// Shared constants and types for the complex FIR decimator.
// Used by cfd_ctrl, cfd_datapath and complex_fir_decimator_top; depends on nothing.
package cfd_pkg;

  localparam int MAX_TAPS     = 64;
  localparam int SAMPLE_WIDTH = 16;
  localparam int COEF_WIDTH   = 18;
  localparam int ACC_WIDTH    = 40;
  localparam int PROD_WIDTH   = SAMPLE_WIDTH + COEF_WIDTH;

  localparam int ADDR_W   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int TAPCNT_W = $clog2(MAX_TAPS + 1);

  // configuration register widths
  localparam int DECIM_W   = 9;
  localparam int TAPREG_W  = 7;
  localparam int CIDX_W    = 6;
  localparam int CFG_DATA_W = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int PHASE_W    = 8;
  localparam int MAX_DECIM  = 256;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DECIMATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_INDEX = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_VALUE = 2'd3;

  localparam int IN_DATA_W  = 2 * SAMPLE_WIDTH;
  localparam int OUT_DATA_W = 2 * ACC_WIDTH;

  // controller to datapath commands
  typedef struct packed {
    logic              wr_en;      // store the incoming sample
    logic [ADDR_W-1:0] wr_addr;
    logic              clear;      // zero the accumulators
    logic              issue;      // read one tap pair
    logic [ADDR_W-1:0] line_addr;
    logic [ADDR_W-1:0] tap_addr;
    logic              load;       // move sums to the output register
  } dp_cmd_t;

  // coefficient write into the tap store
  typedef struct packed {
    logic                         en;
    logic [ADDR_W-1:0]            addr;
    logic signed [COEF_WIDTH-1:0] value;
  } coef_wr_t;

endpackage

### src/cfd_ctrl.sv
// Controller for the complex FIR decimator: handshakes, write pointer,
// decimation phase and tap sequencing. Depends on cfd_pkg.
module cfd_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [cfd_pkg::DECIM_W-1:0]   decimation_i,
  input  logic [cfd_pkg::TAPREG_W-1:0]  tap_count_i,
  output cfd_pkg::dp_cmd_t              cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_DONE
  } state_e;

  state_e                          state_q;
  logic [cfd_pkg::ADDR_W-1:0]      wp_q;
  logic [cfd_pkg::PHASE_W-1:0]     phase_q;
  logic [cfd_pkg::ADDR_W-1:0]      k_q;
  logic [cfd_pkg::ADDR_W-1:0]      pos_q;
  logic                            drain_q;
  logic                            out_vld_q;

  logic                            in_fire;
  logic                            out_free;
  logic                            last_tap;
  logic [cfd_pkg::DECIM_W-1:0]     decim_eff;
  logic [cfd_pkg::TAPCNT_W-1:0]    taps_eff;
  logic [cfd_pkg::PHASE_W:0]       phase_inc;
  logic [cfd_pkg::PHASE_W-1:0]     phase_d;
  logic [cfd_pkg::ADDR_W-1:0]      wp_d;
  logic [cfd_pkg::ADDR_W-1:0]      pos_prev;

  always_comb begin
    if (decimation_i == '0) begin
      decim_eff = cfd_pkg::DECIM_W'(1);
    end else if (int'(decimation_i) > cfd_pkg::MAX_DECIM) begin
      decim_eff = cfd_pkg::DECIM_W'(cfd_pkg::MAX_DECIM);
    end else begin
      decim_eff = decimation_i;
    end

    if (int'(tap_count_i) > cfd_pkg::MAX_TAPS) begin
      taps_eff = cfd_pkg::TAPCNT_W'(cfd_pkg::MAX_TAPS);
    end else begin
      taps_eff = cfd_pkg::TAPCNT_W'(tap_count_i);
    end

    // wrap the phase on overflow or once it reaches the decimation factor
    phase_inc = {1'b0, phase_q} + (cfd_pkg::PHASE_W+1)'(1);
    if (phase_inc[cfd_pkg::PHASE_W-1:0] == '0 ||
        cfd_pkg::DECIM_W'(phase_inc[cfd_pkg::PHASE_W-1:0]) >= decim_eff) begin
      phase_d = '0;
    end else begin
      phase_d = phase_inc[cfd_pkg::PHASE_W-1:0];
    end

    if (int'(wp_q) + 1 >= cfd_pkg::MAX_TAPS) begin
      wp_d = '0;
    end else begin
      wp_d = wp_q + cfd_pkg::ADDR_W'(1);
    end

    if (pos_q == '0) begin
      pos_prev = cfd_pkg::ADDR_W'(cfd_pkg::MAX_TAPS - 1);
    end else begin
      pos_prev = pos_q - cfd_pkg::ADDR_W'(1);
    end
  end

  assign in_fire  = s_axis_tvalid && (state_q == ST_IDLE);
  assign out_free = !out_vld_q || m_axis_tready;
  assign last_tap = (cfd_pkg::TAPCNT_W'(k_q) + cfd_pkg::TAPCNT_W'(1)) == taps_eff;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.wr_en     = in_fire;
    cmd_o.wr_addr   = wp_q;
    cmd_o.clear     = in_fire;
    cmd_o.issue     = (state_q == ST_ISSUE);
    cmd_o.line_addr = pos_q;
    cmd_o.tap_addr  = k_q;
    cmd_o.load      = (state_q == ST_DONE) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wp_q      <= '0;
      phase_q   <= '0;
      k_q       <= '0;
      pos_q     <= '0;
      drain_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_o.load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            wp_q    <= wp_d;
            phase_q <= phase_d;
            if (phase_q == '0) begin
              k_q   <= '0;
              pos_q <= wp_q;
              if (taps_eff == '0) begin
                drain_q <= 1'b1;
                state_q <= ST_DRAIN;
              end else begin
                state_q <= ST_ISSUE;
              end
            end
          end
        end
        ST_ISSUE: begin
          if (last_tap) begin
            drain_q <= 1'b1;
            state_q <= ST_DRAIN;
          end else begin
            k_q   <= k_q + cfd_pkg::ADDR_W'(1);
            pos_q <= pos_prev;
          end
        end
        ST_DRAIN: begin
          // let the read and multiply stages empty into the accumulators
          if (!drain_q) begin
            state_q <= ST_DONE;
          end
          drain_q <= 1'b0;
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### src/cfd_datapath.sv
// Datapath for the complex FIR decimator: delay line, tap store, one shared
// complex multiply-accumulate and the output register. Depends on cfd_pkg.
module cfd_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  cfd_pkg::dp_cmd_t                      cmd_i,
  input  cfd_pkg::coef_wr_t                     coef_wr_i,
  input  logic signed [cfd_pkg::SAMPLE_WIDTH-1:0] sample_i_i,
  input  logic signed [cfd_pkg::SAMPLE_WIDTH-1:0] sample_q_i,
  output logic signed [cfd_pkg::ACC_WIDTH-1:0]    out_i_o,
  output logic signed [cfd_pkg::ACC_WIDTH-1:0]    out_q_o
);

  logic [cfd_pkg::IN_DATA_W-1:0]             line_mem [cfd_pkg::MAX_TAPS];
  logic [cfd_pkg::MAX_TAPS-1:0]              line_vld_q;
  logic signed [cfd_pkg::COEF_WIDTH-1:0]     tap_mem [cfd_pkg::MAX_TAPS];
  logic [cfd_pkg::MAX_TAPS-1:0]              tap_vld_q;

  logic [cfd_pkg::IN_DATA_W-1:0]             line_rd_q;
  logic                                      line_rd_vld_q;
  logic signed [cfd_pkg::COEF_WIDTH-1:0]     tap_rd_q;
  logic                                      tap_rd_vld_q;
  logic                                      rd_vld_q;

  logic signed [cfd_pkg::SAMPLE_WIDTH-1:0]   smp_i;
  logic signed [cfd_pkg::SAMPLE_WIDTH-1:0]   smp_q;
  logic signed [cfd_pkg::COEF_WIDTH-1:0]     coef;

  logic signed [cfd_pkg::PROD_WIDTH-1:0]     prod_i_d, prod_i_q;
  logic signed [cfd_pkg::PROD_WIDTH-1:0]     prod_q_d, prod_q_q;
  logic                                      prod_vld_q;

  logic signed [cfd_pkg::ACC_WIDTH-1:0]      acc_i_q, acc_q_q;
  logic signed [cfd_pkg::ACC_WIDTH-1:0]      out_i_q, out_q_q;

  // storage arrays, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      line_mem[cmd_i.wr_addr] <= {sample_q_i, sample_i_i};
    end
    if (coef_wr_i.en) begin
      tap_mem[coef_wr_i.addr] <= coef_wr_i.value;
    end
    line_rd_q <= line_mem[cmd_i.line_addr];
    tap_rd_q  <= tap_mem[cmd_i.tap_addr];
  end

  // entries never written since reset read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_vld_q    <= '0;
      tap_vld_q     <= '0;
      line_rd_vld_q <= 1'b0;
      tap_rd_vld_q  <= 1'b0;
      rd_vld_q      <= 1'b0;
      prod_vld_q    <= 1'b0;
    end else begin
      if (cmd_i.wr_en) begin
        line_vld_q[cmd_i.wr_addr] <= 1'b1;
      end
      if (coef_wr_i.en) begin
        tap_vld_q[coef_wr_i.addr] <= 1'b1;
      end
      line_rd_vld_q <= line_vld_q[cmd_i.line_addr];
      tap_rd_vld_q  <= tap_vld_q[cmd_i.tap_addr];
      rd_vld_q      <= cmd_i.issue;
      prod_vld_q    <= rd_vld_q;
    end
  end

  always_comb begin
    smp_i = line_rd_vld_q ? line_rd_q[cfd_pkg::SAMPLE_WIDTH-1:0] : '0;
    smp_q = line_rd_vld_q ? line_rd_q[cfd_pkg::IN_DATA_W-1:cfd_pkg::SAMPLE_WIDTH] : '0;
    coef  = tap_rd_vld_q ? tap_rd_q : '0;
    prod_i_d = cfd_pkg::PROD_WIDTH'(smp_i) * cfd_pkg::PROD_WIDTH'(coef);
    prod_q_d = cfd_pkg::PROD_WIDTH'(smp_q) * cfd_pkg::PROD_WIDTH'(coef);
  end

  always_ff @(posedge clk_i) begin
    prod_i_q <= prod_i_d;
    prod_q_q <= prod_q_d;
    if (cmd_i.clear) begin
      acc_i_q <= '0;
      acc_q_q <= '0;
    end else if (prod_vld_q) begin
      acc_i_q <= acc_i_q + cfd_pkg::ACC_WIDTH'(prod_i_q);
      acc_q_q <= acc_q_q + cfd_pkg::ACC_WIDTH'(prod_q_q);
    end
    if (cmd_i.load) begin
      out_i_q <= acc_i_q;
      out_q_q <= acc_q_q;
    end
  end

  assign out_i_o = out_i_q;
  assign out_q_o = out_q_q;

endmodule

### src/complex_fir_decimator_top.sv
// Complex FIR decimator with real taps, 16-bit I/Q in and 40-bit I/Q out.
// Holds the configuration registers; depends on cfd_pkg, cfd_ctrl, cfd_datapath.
//
// A sample that produces no result is taken and the controller stays ready for
// the next. A sample that produces a result (the first after reset, then every
// decimation-th) goes through acceptance, the issue of one tap per cycle, with
// tap_count capped at 64, to the shared complex multiply-accumulate fed by the
// single read port of the delay line and of the tap store, a drain of the read and
// multiply stages and the load of the output register. A finished result waits in
// the output register, so the next sample is taken while it is pending; if the
// following result is ready before that one is taken, the load and the input hold
// until the output register frees. Coefficients are written by setting coef_index
// and then writing coef_value. The delay line and tap store read as zero until
// written, tracked by per-entry valid flops, so no clearing pass runs after reset.
module complex_fir_decimator_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [cfd_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // sample_i, sample_q
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [cfd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // out_i, out_q
  input  logic                             cfg_we_i,
  input  logic [cfd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [cfd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  logic [cfd_pkg::DECIM_W-1:0]             decimation_q;
  logic [cfd_pkg::TAPREG_W-1:0]            tap_count_q;
  logic [cfd_pkg::CIDX_W-1:0]              coef_index_q;

  cfd_pkg::dp_cmd_t                        cmd;
  cfd_pkg::coef_wr_t                       coef_wr;
  logic signed [cfd_pkg::ACC_WIDTH-1:0]    out_i;
  logic signed [cfd_pkg::ACC_WIDTH-1:0]    out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decimation_q <= cfd_pkg::DECIM_W'(1);
      tap_count_q  <= cfd_pkg::TAPREG_W'(64);
      coef_index_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cfd_pkg::CFG_DECIMATION: decimation_q <= cfg_data_i[cfd_pkg::DECIM_W-1:0];
        cfd_pkg::CFG_TAP_COUNT:  tap_count_q  <= cfg_data_i[cfd_pkg::TAPREG_W-1:0];
        cfd_pkg::CFG_COEF_INDEX: coef_index_q <= cfg_data_i[cfd_pkg::CIDX_W-1:0];
        default: ;
      endcase
    end
  end

  // store the coefficient at coef_index; drop it if the index is past the store
  always_comb begin
    coef_wr.en    = cfg_we_i && (cfg_idx_i == cfd_pkg::CFG_COEF_VALUE) &&
                    (int'(coef_index_q) < cfd_pkg::MAX_TAPS);
    coef_wr.addr  = cfd_pkg::ADDR_W'(coef_index_q);
    coef_wr.value = cfg_data_i[cfd_pkg::COEF_WIDTH-1:0];
  end

  cfd_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .decimation_i  (decimation_q),
    .tap_count_i   (tap_count_q),
    .cmd_o         (cmd)
  );

  cfd_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .coef_wr_i  (coef_wr),
    .sample_i_i (s_axis_tdata[cfd_pkg::SAMPLE_WIDTH-1:0]),
    .sample_q_i (s_axis_tdata[cfd_pkg::IN_DATA_W-1:cfd_pkg::SAMPLE_WIDTH]),
    .out_i_o    (out_i),
    .out_q_o    (out_q)
  );

  assign m_axis_tdata = {out_q, out_i};

endmodule
